@@ rtl/fcrg_pkg.sv @@
// Package for the frame checker with replay guard.
// Holds status codes, register indexes, queue sizing, frame constants and the front-to-back queue entry type.
// No dependencies.
package fcrg_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic REG_START_MARKER = 1'b0;
    localparam logic REG_END_MARKER   = 1'b1;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_BAD_START = 3'd2,
        ST_LENGTH    = 3'd3,
        ST_CHECKSUM  = 3'd4,
        ST_BAD_END   = 3'd5,
        ST_REPLAY    = 3'd6
    } t_status;

    localparam logic [15:0] SEQ_WRAP_MARK = 16'hFFFF;
    localparam logic [15:0] MIN_FRAME     = 16'd7;
    localparam logic [16:0] FRAME_OVERHEAD = 17'd8;

    typedef struct packed {
        logic        is_verdict;
        logic [7:0]  data;
        logic [15:0] total;
        logic        start_ok;
        logic [7:0]  running_xor;
        logic [7:0]  checksum;
        logic [7:0]  end_byte;
        logic [7:0]  command;
        logic [15:0] sequence_num;
        logic [15:0] length;
    } t_entry;

endpackage

@@ rtl/frame_check_with_replay_guard.sv @@
// Frame checker with replay guard: one buffer byte per transfer, one per cycle unless full.
// Each payload byte or verdict goes via the queue, then the output register, to the ports.
// 1 byte per cycle unless full; a 4-entry queue and an output register decouple both sides.
// Reset: synchronous, active low; clears parse state, replay guard, queue and markers.
// Depends on fcrg_pkg, fcrg_front, fcrg_queue, fcrg_back.
module frame_check_with_replay_guard (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        empty,
    input  logic        pop,
    output logic        o_is_verdict,
    output logic [7:0]  o_payload_byte,
    output logic [2:0]  o_status,
    output logic [7:0]  o_command_id,
    output logic [15:0] o_sequence_res,
    output logic [15:0] o_body_length,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    logic [7:0] r_start_marker;
    logic [7:0] r_end_marker;
    logic       take;
    logic       q_wr, q_rd, q_full, q_empty;
    fcrg_pkg::t_entry wr_entry, rd_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_marker <= '0;
            r_end_marker   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                fcrg_pkg::REG_START_MARKER: r_start_marker <= i_cfg_data;
                fcrg_pkg::REG_END_MARKER:   r_end_marker   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign full = q_full;
    assign take = push && !q_full;

    fcrg_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_take         (take),
        .i_data         (i_data_byte),
        .i_last         (i_last_byte),
        .i_start_marker (r_start_marker),
        .o_wr           (q_wr),
        .o_entry        (wr_entry)
    );

    fcrg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_entry (wr_entry),
        .i_rd    (q_rd),
        .o_entry (rd_entry),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    fcrg_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_entry        (rd_entry),
        .o_q_rd         (q_rd),
        .i_end_marker   (r_end_marker),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_is_verdict   (o_is_verdict),
        .o_payload_byte (o_payload_byte),
        .o_status       (o_status),
        .o_command_id   (o_command_id),
        .o_sequence_res (o_sequence_res),
        .o_body_length  (o_body_length)
    );

endmodule

@@ rtl/fcrg_front.sv @@
// Front part: walks the frame layout byte by byte and collects header, checksum state.
// Emits one queue entry per payload byte and per last byte. Depends on fcrg_pkg.
module fcrg_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic [7:0]        i_data,
    input  logic              i_last,
    input  logic [7:0]        i_start_marker,
    output logic              o_wr,
    output fcrg_pkg::t_entry  o_entry
);

    logic [15:0] r_pos, n_pos;
    logic        r_start_ok, n_start_ok;
    logic [7:0]  r_cmd, n_cmd;
    logic [15:0] r_seq, n_seq;
    logic [15:0] r_len, n_len;
    logic [7:0]  r_xor, n_xor;
    logic [7:0]  r_cs, n_cs;
    logic [7:0]  r_end, n_end;
    logic        is_pay;
    logic [16:0] cs_idx;
    logic [16:0] pos_x;

    always_comb begin
        n_start_ok = r_start_ok;
        n_cmd      = r_cmd;
        n_seq      = r_seq;
        n_len      = r_len;
        n_xor      = r_xor;
        n_cs       = r_cs;
        n_end      = r_end;
        is_pay     = 1'b0;
        cs_idx     = 17'd6 + {1'b0, r_len};
        pos_x      = {1'b0, r_pos};
        if (r_pos == 16'd0) begin
            n_start_ok = (i_data == i_start_marker);
        end else if (r_pos <= 16'd5) begin
            n_xor = r_xor ^ i_data;
            if (r_pos == 16'd1) begin
                n_cmd = i_data;
            end else if (r_pos == 16'd2) begin
                n_seq = {r_seq[15:8], i_data};
            end else if (r_pos == 16'd3) begin
                n_seq = {i_data, r_seq[7:0]};
            end else if (r_pos == 16'd4) begin
                n_len = {r_len[15:8], i_data};
            end else begin
                n_len = {i_data, r_len[7:0]};
            end
        end else if (pos_x < cs_idx) begin
            n_xor  = r_xor ^ i_data;
            is_pay = 1'b1;
        end else if (pos_x == cs_idx) begin
            n_cs = i_data;
        end else if (pos_x == cs_idx + 17'd1) begin
            n_end = i_data;
        end
        n_pos = (r_pos == 16'hFFFF) ? r_pos : r_pos + 16'd1;
    end

    always_comb begin
        o_entry.is_verdict   = i_last;
        o_entry.data         = i_data;
        o_entry.total        = n_pos;
        o_entry.start_ok     = n_start_ok;
        o_entry.running_xor  = n_xor;
        o_entry.checksum     = n_cs;
        o_entry.end_byte     = n_end;
        o_entry.command      = n_cmd;
        o_entry.sequence_num = n_seq;
        o_entry.length       = n_len;
        o_wr                 = i_take && (i_last || is_pay);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_start_ok <= 1'b0;
            r_cmd      <= '0;
            r_seq      <= '0;
            r_len      <= '0;
            r_xor      <= '0;
            r_cs       <= '0;
            r_end      <= '0;
        end else if (i_take) begin
            if (i_last) begin
                r_pos      <= '0;
                r_start_ok <= 1'b0;
                r_cmd      <= '0;
                r_seq      <= '0;
                r_len      <= '0;
                r_xor      <= '0;
                r_cs       <= '0;
                r_end      <= '0;
            end else begin
                r_pos      <= n_pos;
                r_start_ok <= n_start_ok;
                r_cmd      <= n_cmd;
                r_seq      <= n_seq;
                r_len      <= n_len;
                r_xor      <= n_xor;
                r_cs       <= n_cs;
                r_end      <= n_end;
            end
        end
    end

endmodule

@@ rtl/fcrg_queue.sv @@
// Short queue between front and back parts.
// Register-based ring buffer of fcrg_pkg::t_entry. Depends on fcrg_pkg.
module fcrg_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr,
    input  fcrg_pkg::t_entry  i_entry,
    input  logic              i_rd,
    output fcrg_pkg::t_entry  o_entry,
    output logic              o_full,
    output logic              o_empty
);

    fcrg_pkg::t_entry r_mem [fcrg_pkg::QUEUE_DEPTH];
    logic [fcrg_pkg::QUEUE_AW-1:0] r_wp, r_rp;
    logic [fcrg_pkg::QUEUE_AW:0]   r_cnt;
    logic do_wr, do_rd;

    assign o_full  = (r_cnt == (fcrg_pkg::QUEUE_AW + 1)'(fcrg_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;
    assign o_entry = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_rd) begin
                r_rp <= r_rp + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

@@ rtl/fcrg_back.sv @@
// Back part: judges verdict entries, keeps the replay guard, holds the result register.
// Depends on fcrg_pkg.
module fcrg_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    input  fcrg_pkg::t_entry  i_entry,
    output logic              o_q_rd,
    input  logic [7:0]        i_end_marker,
    input  logic              i_pop,
    output logic              o_empty,
    output logic              o_is_verdict,
    output logic [7:0]        o_payload_byte,
    output logic [2:0]        o_status,
    output logic [7:0]        o_command_id,
    output logic [15:0]       o_sequence_res,
    output logic [15:0]       o_body_length
);

    logic        r_valid;
    logic        r_verdict;
    logic [7:0]  r_payload;
    logic [2:0]  r_status;
    logic [7:0]  r_cmd;
    logic [15:0] r_seq;
    logic [15:0] r_len;
    logic [15:0] r_last_seq;
    fcrg_pkg::t_status status;
    logic        seq_wrap_ok;

    always_comb begin
        seq_wrap_ok = (i_entry.sequence_num == 16'd0) &&
                      ((r_last_seq == 16'd0) || (r_last_seq == fcrg_pkg::SEQ_WRAP_MARK));
        if (i_entry.total < fcrg_pkg::MIN_FRAME) begin
            status = fcrg_pkg::ST_SHORT;
        end else if (!i_entry.start_ok) begin
            status = fcrg_pkg::ST_BAD_START;
        end else if ({1'b0, i_entry.length} + fcrg_pkg::FRAME_OVERHEAD
                     > {1'b0, i_entry.total}) begin
            status = fcrg_pkg::ST_LENGTH;
        end else if (i_entry.running_xor != i_entry.checksum) begin
            status = fcrg_pkg::ST_CHECKSUM;
        end else if (i_entry.end_byte != i_end_marker) begin
            status = fcrg_pkg::ST_BAD_END;
        end else if (!seq_wrap_ok && (i_entry.sequence_num <= r_last_seq)) begin
            status = fcrg_pkg::ST_REPLAY;
        end else begin
            status = fcrg_pkg::ST_OK;
        end
    end

    assign o_q_rd  = !i_q_empty && (!r_valid || i_pop);
    assign o_empty = !r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_last_seq <= '0;
        end else begin
            if (o_q_rd) begin
                r_valid <= 1'b1;
                if (i_entry.is_verdict && (status == fcrg_pkg::ST_OK)) begin
                    r_last_seq <= i_entry.sequence_num;
                end
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_rd) begin
            r_verdict <= i_entry.is_verdict;
            r_payload <= i_entry.is_verdict ? 8'd0 : i_entry.data;
            r_status  <= i_entry.is_verdict ? status : fcrg_pkg::ST_OK;
            r_cmd     <= i_entry.command;
            r_seq     <= i_entry.sequence_num;
            r_len     <= i_entry.length;
        end
    end

    assign o_is_verdict   = r_verdict;
    assign o_payload_byte = r_payload;
    assign o_status       = r_status;
    assign o_command_id   = r_cmd;
    assign o_sequence_res = r_seq;
    assign o_body_length  = r_len;

endmodule

@@ bench/tb_frame_check_with_replay_guard.sv @@
// Testbench for frame_check_with_replay_guard: frames, broken frames and noise buffers
// are sent byte by byte, and every payload byte and verdict is checked against a
// behavioral parser kept in this file. Depends on fcrg_pkg and the RTL of the block.
module tb_frame_check_with_replay_guard;

    localparam int   NUM_PHASES       = 8;
    localparam int   PHASE_BYTES      = 198;
    localparam int   DRAIN_CYCLES     = 20;

    localparam int TX_IDLE[NUM_PHASES]   = '{0, 76, 0, 21, 76, 0, 21, 0};
    localparam int RX_STALL[NUM_PHASES]  = '{0, 0, 76, 21, 0, 76, 21, 0};
    localparam int START_CFG[NUM_PHASES] = '{255, 0, -1, -1, 255, -1, -1, -1};
    localparam int END_CFG[NUM_PHASES]   = '{0, 255, -1, -1, 255, -1, -1, -1};

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_byte_item;

    typedef struct packed {
        logic              is_verdict;
        logic [7:0]        payload;
        fcrg_pkg::t_status status;
        logic [7:0]        command;
        logic [15:0]       seq;
        logic [15:0]       length;
    } t_frame_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  i_data_byte = 8'd0;
    logic        i_last_byte = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic        o_is_verdict;
    logic [7:0]  o_payload_byte;
    logic [2:0]  o_status;
    logic [7:0]  o_command_id;
    logic [15:0] o_sequence_res;
    logic [15:0] o_body_length;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [7:0]  i_cfg_data = 8'd0;

    frame_check_with_replay_guard dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_data_byte    (i_data_byte),
        .i_last_byte    (i_last_byte),
        .empty          (empty),
        .pop            (pop),
        .o_is_verdict   (o_is_verdict),
        .o_payload_byte (o_payload_byte),
        .o_status       (o_status),
        .o_command_id   (o_command_id),
        .o_sequence_res (o_sequence_res),
        .o_body_length  (o_body_length),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    t_byte_item    pending_bytes[$];
    t_frame_result expected_results[$];
    t_frame_result mon_want;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int errors = 0;
    int queued_bytes = 0;
    int bytes_sent = 0;
    int payload_seen = 0;
    int verdicts_by_status[7];

    // parser shadow state
    logic [7:0]  cfg_start = 8'd0;
    logic [7:0]  cfg_end = 8'd0;
    logic [15:0] pos = 16'd0;
    logic        start_seen = 1'b0;
    logic [7:0]  hold_cmd = 8'd0;
    logic [15:0] hold_seq = 16'd0;
    logic [15:0] hold_len = 16'd0;
    logic [7:0]  xor_acc = 8'd0;
    logic [7:0]  rx_csum = 8'd0;
    logic [7:0]  rx_end = 8'd0;
    logic [15:0] last_seq = 16'd0;
    logic [15:0] gen_last_seq = 16'd0;

    task automatic parse_byte(input logic [7:0] b, input logic last);
        int unsigned       i;
        int unsigned       cs_at;
        int unsigned       total;
        logic              in_payload;
        fcrg_pkg::t_status st;
        t_frame_result     r;
        i = 32'(pos);
        cs_at = 6 + 32'(hold_len);
        in_payload = 1'b0;
        if (i == 0) begin
            start_seen = (b == cfg_start);
        end else if (i <= 5) begin
            xor_acc ^= b;
            case (i)
                1: hold_cmd = b;
                2: hold_seq[7:0] = b;
                3: hold_seq[15:8] = b;
                4: hold_len[7:0] = b;
                default: hold_len[15:8] = b;
            endcase
        end else if (i < cs_at) begin
            xor_acc ^= b;
            in_payload = 1'b1;
        end else if (i == cs_at) begin
            rx_csum = b;
        end else if (i == cs_at + 1) begin
            rx_end = b;
        end
        r.command = hold_cmd;
        r.seq = hold_seq;
        r.length = hold_len;
        if (last) begin
            total = i + 1;
            if (total > 65535) total = 65535;
            if (total < 32'(fcrg_pkg::MIN_FRAME)) st = fcrg_pkg::ST_SHORT;
            else if (!start_seen) st = fcrg_pkg::ST_BAD_START;
            else if (32'(hold_len) + 32'(fcrg_pkg::FRAME_OVERHEAD) > total)
                st = fcrg_pkg::ST_LENGTH;
            else if (xor_acc != rx_csum) st = fcrg_pkg::ST_CHECKSUM;
            else if (rx_end != cfg_end) st = fcrg_pkg::ST_BAD_END;
            else if (!(hold_seq == 16'd0 &&
                       (last_seq == 16'd0 || last_seq == fcrg_pkg::SEQ_WRAP_MARK))
                     && hold_seq <= last_seq) st = fcrg_pkg::ST_REPLAY;
            else begin
                st = fcrg_pkg::ST_OK;
                last_seq = hold_seq;
            end
            r.is_verdict = 1'b1;
            r.payload = 8'd0;
            r.status = st;
            expected_results.push_back(r);
            pos = 16'd0;
            start_seen = 1'b0;
            hold_cmd = 8'd0;
            hold_seq = 16'd0;
            hold_len = 16'd0;
            xor_acc = 8'd0;
            rx_csum = 8'd0;
            rx_end = 8'd0;
        end else begin
            if (pos != 16'hFFFF) pos++;
            if (in_payload) begin
                r.is_verdict = 1'b0;
                r.payload = b;
                r.status = fcrg_pkg::ST_OK;
                expected_results.push_back(r);
            end
        end
    endtask

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("mismatch after %0d bytes: %s got 0x%0h want 0x%0h",
                 bytes_sent, what, got, want);
        errors++;
    endtask

    task automatic push_buffer(input logic [7:0] q[$]);
        t_byte_item it;
        foreach (q[k]) begin
            it.data = q[k];
            it.last = (k == q.size() - 1);
            pending_bytes.push_back(it);
        end
        queued_bytes += q.size();
    endtask

    task automatic random_buffer(input int n);
        logic [7:0] q[$];
        repeat (n) q.push_back(8'($urandom));
        push_buffer(q);
    endtask

    task automatic add_frame(input logic [7:0] sb, cmd, input logic [15:0] seq, len,
                             input int pay_n, input logic [7:0] csum_flip, eb,
                             input int trail);
        logic [7:0] q[$];
        logic [7:0] x;
        logic [7:0] p;
        q = {sb, cmd, seq[7:0], seq[15:8], len[7:0], len[15:8]};
        x = cmd ^ seq[7:0] ^ seq[15:8] ^ len[7:0] ^ len[15:8];
        repeat (pay_n) begin
            p = 8'($urandom);
            x ^= p;
            q.push_back(p);
        end
        q.push_back(x ^ csum_flip);
        q.push_back(eb);
        repeat (trail) q.push_back(8'($urandom));
        push_buffer(q);
    endtask

    task automatic write_marker(input logic idx, input logic [7:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        if (idx == fcrg_pkg::REG_START_MARKER) cfg_start = value;
        else cfg_end = value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_bytes.size() != 0 || expected_results.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                parse_byte(i_data_byte, i_last_byte);
                void'(pending_bytes.pop_front());
                bytes_sent++;
            end
            if (!(push && full)) begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    push <= 1'b1;
                    i_data_byte <= pending_bytes[0].data;
                    i_last_byte <= pending_bytes[0].last;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with none expected", 16'(o_payload_byte), 16'd0);
                end else begin
                    mon_want = expected_results.pop_front();
                    if (o_is_verdict !== mon_want.is_verdict)
                        report_mismatch("is_verdict", 16'(o_is_verdict),
                                        16'(mon_want.is_verdict));
                    if (o_payload_byte !== mon_want.payload)
                        report_mismatch("payload_byte", 16'(o_payload_byte),
                                        16'(mon_want.payload));
                    if (o_status !== mon_want.status)
                        report_mismatch("status", 16'(o_status), 16'(mon_want.status));
                    if (o_command_id !== mon_want.command)
                        report_mismatch("command_id", 16'(o_command_id),
                                        16'(mon_want.command));
                    if (o_sequence_res !== mon_want.seq)
                        report_mismatch("sequence_res", o_sequence_res, mon_want.seq);
                    if (o_body_length !== mon_want.length)
                        report_mismatch("body_length", o_body_length, mon_want.length);
                    if (mon_want.is_verdict) verdicts_by_status[mon_want.status]++;
                    else payload_seen++;
                end
            end
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        int          start_count;
        int          kind;
        int          pay_n;
        int          trail;
        int          step_max;
        logic [15:0] seq;
        logic [15:0] len;
        logic [7:0]  sb;
        logic [7:0]  eb;
        logic [7:0]  flip;
        logic [7:0]  q[$];

        foreach (verdicts_by_status[k]) verdicts_by_status[k] = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: one-byte buffer, 7-byte buffer, seq 0 frame, length field beyond the buffer end
        q = {8'hFF};
        push_buffer(q);
        q = {cfg_start, 8'h3C, 8'h01, 8'h00, 8'h00, 8'h00, 8'h3C};
        push_buffer(q);
        add_frame(cfg_start, 8'hC3, 16'h0000, 16'd1, 1, 8'h00, cfg_end, 0);
        q = {cfg_start, 8'h11, 8'h05, 8'h00, 8'h03, 8'h00, 8'hAA, 8'h55};
        push_buffer(q);
        wait_drained();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            send_idle_pct = TX_IDLE[ph];
            recv_stall_pct = RX_STALL[ph];
            write_marker(fcrg_pkg::REG_START_MARKER,
                         (START_CFG[ph] < 0) ? 8'($urandom) : 8'(START_CFG[ph]));
            write_marker(fcrg_pkg::REG_END_MARKER,
                         (END_CFG[ph] < 0) ? 8'($urandom) : 8'(END_CFG[ph]));
            @(negedge i_clk);
            start_count = queued_bytes;
            while (queued_bytes - start_count < PHASE_BYTES) begin
                pay_n = ($urandom_range(9) == 0) ? $urandom_range(12, 40) : $urandom_range(0, 6);
                trail = ($urandom_range(4) == 0) ? $urandom_range(1, 3) : 0;
                len = 16'(pay_n);
                sb = cfg_start;
                eb = cfg_end;
                flip = 8'd0;
                if (gen_last_seq == fcrg_pkg::SEQ_WRAP_MARK) begin
                    seq = 16'd0;
                end else if ($urandom_range(9) == 0) begin
                    seq = fcrg_pkg::SEQ_WRAP_MARK;
                end else begin
                    step_max = 65534 - int'(gen_last_seq);
                    if (step_max > 300) step_max = 300;
                    seq = gen_last_seq + 16'd1 + 16'($urandom_range(0, step_max));
                end
                kind = $urandom_range(99);
                if (kind < 55) begin
                    gen_last_seq = seq;
                end else if (kind < 62) begin
                    sb = cfg_start ^ 8'($urandom_range(1, 255));
                end else if (kind < 68) begin
                    if ($urandom_range(1)) len = 16'(pay_n + trail + $urandom_range(1, 4));
                    else len = 16'($urandom_range(pay_n + trail + 1, 65535));
                end else if (kind < 74) begin
                    flip = 8'($urandom_range(1, 255));
                end else if (kind < 80) begin
                    eb = cfg_end ^ 8'($urandom_range(1, 255));
                end else if (kind < 87) begin
                    seq = gen_last_seq
                        - 16'($urandom_range(0, (gen_last_seq < 5) ? gen_last_seq : 5));
                end
                if (kind < 87) add_frame(sb, 8'($urandom), seq, len, pay_n, flip, eb, trail);
                else if (kind < 93) random_buffer($urandom_range(1, 6));
                else random_buffer($urandom_range(1, 14));
            end
            wait_drained();
        end

        if (expected_results.size() != 0)
            report_mismatch("results never delivered", 16'd0, 16'(expected_results.size()));
        $display("sent %0d bytes over %0d idle/stall phases: %0d payload bytes checked",
                 bytes_sent, NUM_PHASES, payload_seen);
        $display("verdicts ok %0d short %0d start %0d length %0d checksum %0d end %0d replay %0d",
                 verdicts_by_status[fcrg_pkg::ST_OK], verdicts_by_status[fcrg_pkg::ST_SHORT],
                 verdicts_by_status[fcrg_pkg::ST_BAD_START],
                 verdicts_by_status[fcrg_pkg::ST_LENGTH],
                 verdicts_by_status[fcrg_pkg::ST_CHECKSUM],
                 verdicts_by_status[fcrg_pkg::ST_BAD_END],
                 verdicts_by_status[fcrg_pkg::ST_REPLAY]);
        if (errors == 0) begin
            $display("tb_frame_check_with_replay_guard: PASS");
        end else begin
            $display("tb_frame_check_with_replay_guard: FAIL");
        end
        $finish;
    end

    initial begin
        #(8 * 3_000_000);
        $display("timeout after %0d bytes", bytes_sent);
        $display("tb_frame_check_with_replay_guard: FAIL");
        $finish;
    end

endmodule

@@ files.f @@
rtl/fcrg_pkg.sv
rtl/fcrg_front.sv
rtl/fcrg_queue.sv
rtl/fcrg_back.sv
rtl/frame_check_with_replay_guard.sv
bench/tb_frame_check_with_replay_guard.sv
